[rtl/tridiagonal_system_solver_defines.svh]
// ----------------------------------------------------------------------------
// Tridiagonal solver assertion macros
// Shared assertion helpers for the solver RTL.
// ----------------------------------------------------------------------------
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_DEFINES_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_DEFINES_SVH

// Concurrent implication checked on every clock edge outside reset.
`define TDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Concurrent next-cycle implication checked outside reset.
`define TDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/tds_pkg.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver package
// Shared types, constants and helpers for the solver blocks.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int unsigned MaxRowsDefault  = 64;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned IdxW            = 6;
  localparam int unsigned CntW            = 7;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusPivot    = 2'd1,
    StatusOverflow = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] sub_diag;
    logic signed [31:0] main_diag;
    logic signed [31:0] super_diag;
    logic signed [31:0] rhs_value;
    logic               final_row;
  } row_t;

  typedef struct packed {
    logic signed [31:0] solution;
    logic [IdxW-1:0]    row_index;
    logic [1:0]         status;
    logic               last_result;
  } res_t;

  typedef struct packed {
    row_t            row;
    logic [CntW-1:0] row_num;
    logic            overflow;
  } job_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

[rtl/tds_front.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver front end
// Accepts row beats, numbers them and flags rows beyond storage.
// ----------------------------------------------------------------------------
module tds_front #(
  parameter int unsigned MaxRows = tds_pkg::MaxRowsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tds_pkg::row_t in_data_i,
  output logic          q_valid_o,
  input  logic          q_stall_i,
  output tds_pkg::job_t q_data_o
);
  import tds_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic [1:0]      fill_q, fill_d;
  job_t            fifo_q [2];
  logic            wp_q, rp_q;
  logic            push, pop;

  assign in_stall_o = (fill_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (fill_q != 2'd0);
  assign pop        = q_valid_o && !q_stall_i;
  assign q_data_o   = fifo_q[rp_q];

  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    fill_d = fill_q + {1'b0, push} - {1'b0, pop};
    if (push) begin
      if (in_data_i.final_row) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (cnt_q >= CntW'(MaxRows)) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      fill_q <= '0;
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      fill_q <= fill_d;
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q].row      <= in_data_i;
      fifo_q[wp_q].row_num  <= cnt_q;
      fifo_q[wp_q].overflow <= ovf_q || (cnt_q >= CntW'(MaxRows));
    end
  end

endmodule

[rtl/tds_back.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver back end
// Forward sweep with a serial divider, then back substitution.
// ----------------------------------------------------------------------------
`include "tridiagonal_system_solver_defines.svh"
module tds_back #(
  parameter int unsigned MaxRows  = tds_pkg::MaxRowsDefault,
  parameter int unsigned FracBits = tds_pkg::FracBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_stall_o,
  input  tds_pkg::job_t q_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tds_pkg::res_t out_data_o
);
  import tds_pkg::*;

  localparam int unsigned AddrW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned DivW  = 32 + FracBits;

  typedef enum logic [10:0] {
    SIdle  = 11'b00000000001,
    SMul   = 11'b00000000010,
    SSub   = 11'b00000000100,
    SDivC  = 11'b00000001000,
    SDivD  = 11'b00000010000,
    SFin   = 11'b00000100000,
    SRead  = 11'b00001000000,
    SBMul  = 11'b00010000000,
    SBSub  = 11'b00100000000,
    SEmit  = 11'b01000000000,
    SErr   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0] mem_c [MaxRows];
  logic signed [31:0] mem_d [MaxRows];
  logic signed [31:0] rd_c_q, rd_d_q;
  logic signed [31:0] prev_c_q, prev_d_q;
  logic               piv_err_q;
  job_t               job_q;
  logic signed [63:0] p1_q, p2_q;
  logic signed [31:0] piv_q, rhs_q, cres_q, x_q;
  logic [AddrW-1:0]   bidx_q;
  logic               bfirst_q;
  logic [1:0]         err_st_q;

  // restoring divider on magnitudes
  logic [DivW-1:0]    dq_q;
  logic [32:0]        drem_q;
  logic [31:0]        dden_q;
  logic               dneg_q;
  logic [6:0]         dcnt_q;
  logic [33:0]        dtrial;

  logic               ovalid_q;
  res_t               odata_q;

  logic               take;
  logic               out_free;
  logic               emit_fire;
  logic signed [31:0] div_res;
  logic signed [DivW:0] div_signed;

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign out_free    = !ovalid_q || !out_stall_i;
  assign emit_fire   = (state_q == SEmit || state_q == SErr) && out_free;
  assign q_stall_o   = (state_q != SIdle);
  assign take        = q_valid_i && (state_q == SIdle);
  assign dtrial      = {drem_q, dq_q[DivW-1]} - {2'b0, dden_q};
  assign div_signed  = dneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

  always_comb begin
    div_res = sat32(66'(div_signed));
  end

  function automatic logic signed [63:0] fxm(input logic signed [63:0] p);
    return (p + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
  endfunction

  task automatic noop();
  endtask

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (take) begin
        if (q_data_i.overflow || piv_err_q) begin
          state_d = q_data_i.row.final_row ? SErr : SIdle;
        end else begin
          state_d = SMul;
        end
      end
      SMul:  state_d = SSub;
      SSub:  state_d = (piv_q == 0) ? SFin : SDivC;
      SDivC: if (dcnt_q == 0) state_d = SDivD;
      SDivD: if (dcnt_q == 0) state_d = SFin;
      SFin: begin
        if (!job_q.row.final_row) state_d = SIdle;
        else if (piv_err_q) state_d = SErr;
        else state_d = SEmit;
      end
      SRead: state_d = SBMul;
      SBMul: state_d = SBSub;
      SBSub: state_d = SEmit;
      SEmit: if (out_free) state_d = (bidx_q != 0) ? SRead : SIdle;
      SErr:  if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
    if (state_q == SEmit && out_free && bidx_q == 0 && !bfirst_q) state_d = SIdle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      piv_err_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= emit_fire || (ovalid_q && out_stall_i);
      if (take && (q_data_i.overflow || piv_err_q) && q_data_i.row.final_row) begin
        piv_err_q <= piv_err_q;
      end
      if (state_q == SSub && piv_q == 0) piv_err_q <= 1'b1;
      if (state_q == SErr && out_free) begin
        piv_err_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SIdle: if (take) begin
        job_q    <= q_data_i;
        p1_q     <= $signed(prev_c_q) * $signed(q_data_i.row.sub_diag);
        p2_q     <= $signed(q_data_i.row.sub_diag) * $signed(prev_d_q);
        err_st_q <= q_data_i.overflow ? StatusOverflow : StatusPivot;
      end
      SMul: begin
        if (job_q.row_num == 0) begin
          piv_q <= job_q.row.main_diag;
          rhs_q <= job_q.row.rhs_value;
        end else begin
          piv_q <= sat32(66'(job_q.row.main_diag) - 66'(fxm(p1_q)));
          rhs_q <= sat32(66'(job_q.row.rhs_value) - 66'(fxm(p2_q)));
        end
      end
      SSub: begin
        dq_q   <= DivW'($unsigned(job_q.row.super_diag[31] ? -33'(job_q.row.super_diag)
                                 : 33'(job_q.row.super_diag))) << FracBits;
        dden_q <= piv_q[31] ? 32'(-33'(piv_q)) : piv_q;
        dneg_q <= job_q.row.super_diag[31] ^ piv_q[31];
        drem_q <= '0;
        dcnt_q <= 7'(DivW);
      end
      SDivC: begin
        if (dcnt_q != 0) begin
          dcnt_q <= dcnt_q - 1'b1;
          if (!dtrial[33]) begin
            drem_q <= dtrial[32:0];
            dq_q   <= {dq_q[DivW-2:0], 1'b1};
          end else begin
            drem_q <= {drem_q[31:0], dq_q[DivW-1]};
            dq_q   <= {dq_q[DivW-2:0], 1'b0};
          end
        end else begin
          cres_q <= div_res;
          dq_q   <= DivW'($unsigned(rhs_q[31] ? -33'(rhs_q) : 33'(rhs_q))) << FracBits;
          dneg_q <= rhs_q[31] ^ piv_q[31];
          drem_q <= '0;
          dcnt_q <= 7'(DivW);
        end
      end
      SDivD: begin
        if (dcnt_q != 0) begin
          dcnt_q <= dcnt_q - 1'b1;
          if (!dtrial[33]) begin
            drem_q <= dtrial[32:0];
            dq_q   <= {dq_q[DivW-2:0], 1'b1};
          end else begin
            drem_q <= {drem_q[31:0], dq_q[DivW-1]};
            dq_q   <= {dq_q[DivW-2:0], 1'b0};
          end
        end else begin
          mem_c[job_q.row_num[AddrW-1:0]] <= cres_q;
          mem_d[job_q.row_num[AddrW-1:0]] <= div_res;
          prev_c_q <= cres_q;
          prev_d_q <= div_res;
          x_q      <= div_res;
        end
      end
      SFin: begin
        bidx_q   <= job_q.row_num[AddrW-1:0];
        bfirst_q <= 1'b1;
        err_st_q <= StatusPivot;
      end
      SRead: begin
        bidx_q <= bidx_q - 1'b1;
        rd_c_q <= mem_c[bidx_q - 1'b1];
        rd_d_q <= mem_d[bidx_q - 1'b1];
      end
      SBMul: p1_q <= $signed(rd_c_q) * $signed(x_q);
      SBSub: x_q  <= sat32(66'(rd_d_q) - 66'(fxm(p1_q)));
      SEmit: if (out_free) begin
        bfirst_q            <= 1'b0;
        odata_q.solution    <= x_q;
        odata_q.row_index   <= IdxW'(bidx_q);
        odata_q.status      <= StatusOk;
        odata_q.last_result <= (bidx_q == 0);
      end
      SErr: if (out_free) begin
        odata_q.solution    <= '0;
        odata_q.row_index   <= '0;
        odata_q.status      <= err_st_q;
        odata_q.last_result <= 1'b1;
      end
      default: noop();
    endcase
  end

  `TDS_ASSERT_IMPL(a_stall_busy, clk_i, rst_ni, state_q != SIdle, q_stall_o)
  `TDS_ASSERT_NEXT(a_err_last, clk_i, rst_ni, state_q == SErr && out_free,
                   out_valid_o && out_data_o.last_result)
  `TDS_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, state_q == SEmit && out_free, out_valid_o)

endmodule

[rtl/tridiagonal_system_solver.sv]
// In the forward sweep a bit-serial divider forms both the scaled super-diagonal
// and the right-hand side of each row; no new row is taken until it is through.
// After the final row, back substitution reads, multiplies, subtracts and emits
// each earlier unknown. An error flagged by an earlier row is reported through the
// error state once the final row is taken, as is a zero pivot on the final row.
// Reset is asynchronous and active low; it clears counters, flags and valid bits.
// ----------------------------------------------------------------------------
// Tridiagonal system solver
// Thomas algorithm in saturating fixed point, one row per input beat.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver #(
  parameter int unsigned MaxRows  = tds_pkg::MaxRowsDefault,
  parameter int unsigned FracBits = tds_pkg::FracBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tds_pkg::row_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tds_pkg::res_t out_data_o
);
  import tds_pkg::*;

  logic q_valid, q_stall;
  job_t q_data;

  tds_front #(.MaxRows(MaxRows)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .q_valid_o(q_valid), .q_stall_i(q_stall), .q_data_o(q_data)
  );

  tds_back #(.MaxRows(MaxRows), .FracBits(FracBits)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_stall_o(q_stall), .q_data_i(q_data),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

endmodule
